/* design/ptt_pkg.sv */
// ptt_pkg: shared types and constants of the periodic timer table
// command and status codes, sequencer states, table entry and result word
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

    // command codes carried on the input selector
    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_ERASE   = 3'd1;
    localparam logic [2:0] CMD_SUSPEND = 3'd2;
    localparam logic [2:0] CMD_WAKEUP  = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;
    localparam logic [2:0] CMD_TICK    = 3'd5;

    // status codes of an acknowledgement
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_DUP      = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    // result kinds
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_FIRED = 1'b1;

    // packed widths of the stream words
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 40;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } seq_state_t;

    // one table entry as held in the memory
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] period;
        logic [63:0] deadline;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one result word
    typedef struct packed {
        logic        kind;
        logic [31:0] fired_id;
        logic [1:0]  status;
        logic        last;
    } result_t;

    // request from the sequencer to the output register
    typedef struct packed {
        logic    push;
        result_t res;
    } res_req_t;

endpackage

`default_nettype wire

/* design/ptt_ram.sv */
// ptt_ram: generic single-port-write, single-port-read memory
// registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ptt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/ptt_out.sv */
// ptt_out: output holding register of the result stream
// depends on ptt_pkg for the result word
`timescale 1ns / 1ps
`default_nettype none

module ptt_out
    import ptt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire res_req_t              req,
    output logic                       push_ok,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [0:0]                 m_tuser,
    output logic                       m_tlast
);

    logic    valid_reg;
    result_t res_reg;

    // a new word may enter when the register is empty or drains this cycle
    assign push_ok = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (req.push) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.push) begin
            res_reg <= req.res;
        end
    end

    // port packing
    assign m_tvalid   = valid_reg;
    assign m_tdata    = {{(OUT_DATA_W - 34){1'b0}}, res_reg.status, res_reg.fired_id};
    assign m_tuser[0] = res_reg.kind;
    assign m_tlast    = res_reg.last;

endmodule

`default_nettype wire

/* design/ptt_seq.sv */
// ptt_seq: command sequencer of the periodic timer table
// scans the entry memory, keeps valid, parked and pending bits and the time
// depends on ptt_pkg; drives one ptt_ram instance and the output register
`timescale 1ns / 1ps
`default_nettype none

module ptt_seq
    import ptt_pkg::*;
#(
    parameter int SLOTS = 16,
    localparam int IW = $clog2(SLOTS)
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [2:0]     in_cmd,
    input  wire logic [31:0]    in_id,
    input  wire logic [31:0]    in_period,
    input  wire logic           push_ok,
    output res_req_t            req,
    output logic                ram_we,
    output logic [IW-1:0]       ram_waddr,
    output entry_t              ram_wdata,
    output logic                ram_re,
    output logic [IW-1:0]       ram_raddr,
    input  wire entry_t         ram_rdata
);

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    seq_state_t state_reg, state_next;

    // control state
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SLOTS-1:0] parked_reg, parked_next;
    logic [SLOTS-1:0] pend_reg, pend_next;
    logic [63:0]      time_reg, time_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             issue_done_reg, issue_done_next;
    logic             found_reg, found_next;
    logic             free_found_reg, free_found_next;
    logic             first_pass_reg, first_pass_next;

    // payload state
    logic [2:0]    cmd_reg, cmd_next;
    logic [31:0]   id_reg, id_next;
    logic [31:0]   period_reg, period_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0] found_idx_reg, found_idx_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [31:0]   found_id_reg, found_id_next;
    logic [31:0]   found_per_reg, found_per_next;
    logic [63:0]   found_dl_reg, found_dl_next;

    logic        scan_end;
    logic        in_no_scan;
    logic        cand;
    logic        due;
    logic [31:0] addend;
    logic [63:0] new_deadline;

    assign scan_end   = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign in_no_scan = (in_cmd == CMD_CLEAR) || (in_cmd > CMD_TICK);

    // shared deadline adder
    assign addend       = (cmd_reg == CMD_ADD) ? period_reg : found_per_reg;
    assign new_deadline = time_reg + {32'd0, addend};

    // due test of the entry being compared
    assign due = valid_reg[cmp_idx_reg] && !parked_reg[cmp_idx_reg]
                 && (ram_rdata.deadline <= time_reg);
    assign cand = first_pass_reg ? due : pend_reg[cmp_idx_reg];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = in_no_scan ? ST_APPLY : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (push_ok) begin
                    state_next = (cmd_reg == CMD_TICK && found_reg) ? ST_SCAN : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        valid_next      = valid_reg;
        parked_next     = parked_reg;
        pend_next       = pend_reg;
        time_next       = time_reg;
        cmp_vld_next    = 1'b0;
        issue_done_next = issue_done_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        first_pass_next = first_pass_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        period_next     = period_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_idx_next  = found_idx_reg;
        free_idx_next   = free_idx_reg;
        found_id_next   = found_id_reg;
        found_per_next  = found_per_reg;
        found_dl_next   = found_dl_reg;

        in_ready     = 1'b0;
        req          = '0;
        ram_we       = 1'b0;
        ram_waddr    = found_idx_reg;
        ram_wdata    = '{id: id_reg, period: found_per_reg, deadline: new_deadline};
        ram_re       = 1'b0;
        ram_raddr    = rd_idx_reg;

        unique case (state_reg)
            // take a command and arm the first pass
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next        = in_cmd;
                    id_next         = in_id;
                    period_next     = in_period;
                    first_pass_next = (in_cmd == CMD_TICK);
                    if (in_cmd == CMD_TICK) begin
                        time_next = time_reg + 64'd1;
                    end
                    rd_idx_next     = '0;
                    issue_done_next = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                end
            end

            // read every entry once, compare each in the cycle after its read
            ST_SCAN: begin
                ram_re       = !issue_done_reg;
                cmp_vld_next = !issue_done_reg;
                cmp_idx_next = rd_idx_reg;
                if (!issue_done_reg) begin
                    if (rd_idx_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end else begin
                        rd_idx_next = rd_idx_reg + IW'(1);
                    end
                end
                if (cmp_vld_reg) begin
                    if (cmd_reg == CMD_TICK) begin
                        // earliest pending deadline, lower slot wins ties
                        if (first_pass_reg) begin
                            pend_next[cmp_idx_reg] = due;
                        end
                        if (cand && (!found_reg || ram_rdata.deadline < found_dl_reg)) begin
                            found_next     = 1'b1;
                            found_idx_next = cmp_idx_reg;
                            found_id_next  = ram_rdata.id;
                            found_per_next = ram_rdata.period;
                            found_dl_next  = ram_rdata.deadline;
                        end
                    end else begin
                        // lowest valid slot holding the id
                        if (!found_reg && valid_reg[cmp_idx_reg]
                            && ram_rdata.id == id_reg) begin
                            found_next     = 1'b1;
                            found_idx_next = cmp_idx_reg;
                            found_per_next = ram_rdata.period;
                        end
                        // lowest free slot
                        if (!free_found_reg && !valid_reg[cmp_idx_reg]) begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                    end
                end
            end

            // update the table and emit one result word
            ST_APPLY: begin
                if (push_ok) begin
                    req.push         = 1'b1;
                    req.res.kind     = KIND_ACK;
                    req.res.fired_id = id_reg;
                    req.res.status   = STAT_OK;
                    req.res.last     = 1'b1;
                    unique case (cmd_reg)
                        CMD_ADD: begin
                            if (found_reg) begin
                                req.res.status = STAT_DUP;
                            end else if (!free_found_reg) begin
                                req.res.status = STAT_FULL;
                            end else begin
                                ram_we                  = 1'b1;
                                ram_waddr               = free_idx_reg;
                                ram_wdata.period        = period_reg;
                                valid_next[free_idx_reg]  = 1'b1;
                                parked_next[free_idx_reg] = 1'b0;
                            end
                        end
                        CMD_ERASE, CMD_SUSPEND, CMD_WAKEUP: begin
                            if (!found_reg) begin
                                req.res.status = STAT_NOTFOUND;
                            end else if (cmd_reg == CMD_ERASE) begin
                                valid_next[found_idx_reg]  = 1'b0;
                                parked_next[found_idx_reg] = 1'b0;
                            end else if (cmd_reg == CMD_SUSPEND) begin
                                parked_next[found_idx_reg] = 1'b1;
                            end else begin
                                ram_we                     = 1'b1;
                                parked_next[found_idx_reg] = 1'b0;
                            end
                        end
                        CMD_CLEAR: begin
                            valid_next       = '0;
                            parked_next      = '0;
                            req.res.fired_id = 32'd0;
                        end
                        CMD_TICK: begin
                            if (found_reg) begin
                                // fire, reschedule and run another pass
                                req.res.kind     = KIND_FIRED;
                                req.res.fired_id = found_id_reg;
                                req.res.last     = 1'b0;
                                ram_we           = 1'b1;
                                ram_wdata.id     = found_id_reg;
                                pend_next[found_idx_reg] = 1'b0;
                                first_pass_next  = 1'b0;
                                rd_idx_next      = '0;
                                issue_done_next  = 1'b0;
                                found_next       = 1'b0;
                                free_found_next  = 1'b0;
                            end else begin
                                req.res.fired_id = 32'd0;
                            end
                        end
                        default: begin
                            req.res.fired_id = 32'd0;
                        end
                    endcase
                end
            end

            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            parked_reg     <= '0;
            pend_reg       <= '0;
            time_reg       <= '0;
            cmp_vld_reg    <= 1'b0;
            issue_done_reg <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            first_pass_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            parked_reg     <= parked_next;
            pend_reg       <= pend_next;
            time_reg       <= time_next;
            cmp_vld_reg    <= cmp_vld_next;
            issue_done_reg <= issue_done_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            first_pass_reg <= first_pass_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        period_reg    <= period_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        found_id_reg  <= found_id_next;
        found_per_reg <= found_per_next;
        found_dl_reg  <= found_dl_next;
    end

endmodule

`default_nettype wire

/* design/periodic_timer_table_unit.sv */
// periodic_timer_table_unit: top level of the periodic timer table
// depends on ptt_pkg, ptt_ram, ptt_seq and ptt_out
//
// Usage: the input stream carries one command per word: s_tuser is the
// command (add, erase, suspend, wakeup, clear, tick), s_tdata holds the
// timer id and the period. The result stream gives one or more words per
// command: m_tuser is the kind (acknowledgement or timer fired), m_tdata
// holds the id and the status, m_tlast marks the final word of a command.
// Timer entries (id, period, deadline) live in one memory with a registered
// read port; valid, parked and pending bits and the time are flip-flops.
// Clear and unknown codes skip the memory scan. Add, erase, suspend and
// wakeup each take one scan of the memory. A tick takes one scan per fired
// timer plus one more; the single memory read port sets this.
// A new command is taken once the previous one has handed its final word to
// the output register, so it may enter while that word still waits.
// A stalled receiver holds the block at the next word it must emit.
// Reset empties the table and zeroes the time; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_table_unit
    import ptt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // timer_id [31:0], period [63:32]
    input  wire logic [IN_USER_W-1:0]  s_tuser,   // cmd [2:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // fired_id [31:0], status [33:32]
    output logic [0:0]                 m_tuser,   // kind [0]
    output logic                       m_tlast
);

    localparam int IW = $clog2(SLOTS);

    res_req_t      res_req;
    logic          push_ok;
    logic          ram_we;
    logic          ram_re;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;

    // command sequencer
    ptt_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser[2:0]),
        .in_id     (s_tdata[31:0]),
        .in_period (s_tdata[63:32]),
        .push_ok   (push_ok),
        .req       (res_req),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // timer entry memory
    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result word register
    ptt_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (res_req),
        .push_ok  (push_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a word is only pushed when the output register can take it
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_req.push |-> (!m_tvalid || m_tready))
        else $error("result pushed into a full output register");

    // no result is produced while the block waits for a command
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !res_req.push)
        else $error("result produced while idle");

    // the memory is never written during a scan read
    a_ram_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !ram_re)
        else $error("memory written and read in the same cycle");

endmodule

`default_nettype wire
